// File: hdl/pea_pkg.sv
`timescale 1ns / 1ps
package pea_pkg;
  localparam int CountBitsDef = 16;
  localparam int AtanIterDef  = 18;
  localparam int TableLen     = 24;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic [19:0] TwoPiQ16 = 20'd411775;
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CmdEst    = 2'd0;
  localparam logic [1:0] CmdTrue   = 2'd1;
  localparam logic [1:0] CmdTick   = 2'd2;
  localparam logic [1:0] CmdReport = 2'd3;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0: r = 30'd843314857;
        5'd1: r = 30'd497837829;
        5'd2: r = 30'd263043837;
        5'd3: r = 30'd133525159;
        5'd4: r = 30'd67021687;
        5'd5: r = 30'd33543516;
        5'd6: r = 30'd16775851;
        5'd7: r = 30'd8388437;
        5'd8: r = 30'd4194283;
        5'd9: r = 30'd2097149;
        default: r = (i < 5'd24) ? (30'd1 << (5'd30 - i)) : 30'd0;
      endcase
      return r;
    end
  endfunction
endpackage

// File: hdl/pea_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC yaw, one micro-rotation per cycle.
module pea_cordic #(
  parameter int AtanIterations = pea_pkg::AtanIterDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] qx_i,
  input  logic signed [15:0] qy_i,
  input  logic signed [15:0] qz_i,
  input  logic signed [15:0] qw_i,
  output logic               done_o,
  output logic signed [19:0] yaw_o
);
  localparam int NIter = (AtanIterations < pea_pkg::TableLen) ? AtanIterations
                                                              : pea_pkg::TableLen;
  localparam logic [1:0] StIdle = 2'd0, StProd = 2'd1, StRot = 2'd2, StFin = 2'd3;

  logic [1:0] st_q, st_d;
  logic [4:0] it_q, it_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [36:0] z_q, z_d;
  logic               zero_q, zero_d;
  logic signed [19:0] yaw_q, yaw_d;

  logic signed [33:0] s_w, c_w;
  logic signed [35:0] xs_w, ys_w;
  logic signed [37:0] rnd_w;
  logic signed [23:0] r_w;

  always_comb begin
    s_w = 34'(2 * (34'(qw_i) * 34'(qz_i) + 34'(qx_i) * 34'(qy_i)));
    c_w = 34'(34'sd268435456 - 2 * (34'(qy_i) * 34'(qy_i) + 34'(qz_i) * 34'(qz_i)));
    xs_w = x_q >>> it_q;
    ys_w = y_q >>> it_q;
    rnd_w = 38'(z_q) + 38'sd8192;
    r_w = 24'(rnd_w >>> 14);
  end

  always_comb begin
    st_d = st_q; it_d = it_q; x_d = x_q; y_d = y_q; z_d = z_q;
    zero_d = zero_q; yaw_d = yaw_q; done_o = 1'b0;
    unique case (st_q)
      StIdle: if (start_i) st_d = StProd;
      StProd: begin
        zero_d = (s_w == 0) && (c_w == 0);
        it_d = '0;
        if (c_w < 0) begin
          x_d = -36'(c_w); y_d = -36'(s_w);
          z_d = (s_w >= 0) ? 37'(pea_pkg::PiQ30) : -37'(pea_pkg::PiQ30);
        end else begin
          x_d = 36'(c_w); y_d = 36'(s_w); z_d = '0;
        end
        st_d = StRot;
      end
      StRot: begin
        if (y_q > 0) begin
          x_d = x_q + ys_w; y_d = y_q - xs_w;
          z_d = z_q + 37'(pea_pkg::atan_q30(it_q));
        end else begin
          x_d = x_q - ys_w; y_d = y_q + xs_w;
          z_d = z_q - 37'(pea_pkg::atan_q30(it_q));
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(NIter - 1)) st_d = StFin;
      end
      StFin: begin
        if (zero_q) yaw_d = '0;
        else if (r_w > 24'(pea_pkg::PiQ16)) yaw_d = pea_pkg::PiQ16;
        else if (r_w < -24'(pea_pkg::PiQ16)) yaw_d = -pea_pkg::PiQ16;
        else yaw_d = 20'(r_w);
        done_o = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end
  always_ff @(posedge clk_i) begin
    it_q <= it_d; x_q <= x_d; y_q <= y_d; z_q <= z_d; zero_q <= zero_d; yaw_q <= yaw_d;
  end
  assign yaw_o = yaw_d;

`ifndef SYNTHESIS
  a_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRot |-> it_q < 5'(NIter)) else $error("cordic iteration overrun");
  a_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (yaw_o <= pea_pkg::PiQ16 && yaw_o >= -pea_pkg::PiQ16))
    else $error("yaw out of range");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q == StIdle && start_i) |-> st_q == StProd) else $error("start lost");
`endif
endmodule

// File: hdl/pea_arith.sv
`timescale 1ns / 1ps
// Shared bit-serial unit: restoring divide (op 0) or integer square root (op 1).
module pea_arith (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [64:0] num_i,
  input  logic [47:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [47:0] quo_o,
  output logic [32:0] root_o
);
  logic        busy_q, op_q, done_q;
  logic [6:0]  cnt_q;
  logic [64:0] v_q;
  logic [48:0] rem_q;
  logic [47:0] quo_q, den_q;
  logic [66:0] res_q;
  logic [48:0] trem_w;
  logic [66:0] bit_w, trial_w;

  assign bit_w   = 67'd1 << {cnt_q[5:0], 1'b0};
  assign trial_w = res_q + bit_w;
  assign trem_w  = {rem_q[47:0], v_q[47]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; op_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1; op_q <= sqrt_i;
        cnt_q <= sqrt_i ? 7'd32 : 7'd47;
      end else if (busy_q) begin
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0; done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      v_q <= num_i; den_q <= den_i; rem_q <= '0; quo_q <= '0; res_q <= '0;
    end else if (busy_q) begin
      if (op_q) begin
        if (67'(v_q) >= trial_w) begin
          v_q <= 65'(67'(v_q) - trial_w);
          res_q <= (res_q >> 1) + bit_w;
        end else begin
          res_q <= res_q >> 1;
        end
      end else begin
        v_q <= {v_q[63:0], 1'b0};
        if (trem_w >= {1'b0, den_q}) begin
          rem_q <= trem_w - {1'b0, den_q};
          quo_q <= {quo_q[46:0], 1'b1};
        end else begin
          rem_q <= trem_w;
          quo_q <= {quo_q[46:0], 1'b0};
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign root_o = res_q[32:0];

`ifndef SYNTHESIS
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && cnt_q == 7'd0 |=> done_o) else $error("missing done");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> cnt_q <= 7'd47) else $error("count range");
`endif
endmodule

// File: hdl/pose_error_averager_unit.sv
`timescale 1ns / 1ps
// Pose error averager.
// Input channel: cmd_i with pose fields; beat accepted when valid_i && !stall_o.
//   cmd 0/1 store an estimated/true pose and its yaw, 2 takes a sample once both
//   poses are seen and the count is not full, 3 reports averages and clears the sums.
// Output channel: one beat per report, held on valid_o until !stall_i.
// Work per beat: pose runs the CORDIC, one rotation per cycle; tick runs the
//   bit-serial square root; report runs two 48-step serial divisions in the
//   same shared unit.
// One beat is in flight at a time; stall_o is high while working and while
// a report beat waits, so a stalled receiver holds the block.
// Reset clears both poses, seen flags, sums and count, and drops any output.
module pose_error_averager_unit #(
  parameter int COUNT_BITS      = pea_pkg::CountBitsDef,
  parameter int ATAN_ITERATIONS = pea_pkg::AtanIterDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               status_o,
  output logic [31:0]        avg_linear_error_o,
  output logic [17:0]        avg_angular_error_o,
  output logic [15:0]        samples_used_o
);
  localparam logic [3:0] StIdle = 4'd0, StYaw = 4'd1, StSq = 4'd2, StRoot = 4'd3,
                         StAcc = 4'd4, StDivL = 4'd5, StDivA = 4'd6, StOut = 4'd7,
                         StSqWait = 4'd8;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [3:0] st_q;
  logic [1:0] cmd_q;
  logic signed [31:0] px_q, py_q, ex_q, ey_q, tx_q, ty_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [19:0] ey_aw_q, ty_aw_q;
  logic est_seen_q, true_seen_q;
  logic [47:0] lsum_q, asum_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [64:0] sq_q;
  logic [31:0] dist_q;
  logic [17:0] ang_q;
  logic ovf_q;
  logic valid_q, status_q;
  logic [31:0] avl_q;
  logic [17:0] ava_q;
  logic [15:0] su_q;

  logic cor_done;
  logic signed [19:0] yaw_w;
  logic ar_start, ar_sqrt, ar_busy, ar_done;
  logic [64:0] ar_num;
  logic [47:0] ar_den, ar_quo;
  logic [32:0] ar_root;
  logic signed [32:0] dx_w, dy_w;
  logic [32:0] ax_w, ay_w;
  logic signed [20:0] da_w;
  logic [20:0] ada_w;
  logic [20:0] am_w;
  logic [48:0] lsum_w, asum_w;
  logic cor_go_q;

  pea_cordic #(.AtanIterations(ATAN_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_go_q), .qx_i(qx_q), .qy_i(qy_q), .qz_i(qz_q),
    .qw_i(qw_q), .done_o(cor_done), .yaw_o(yaw_w));

  pea_arith u_arith (
    .clk_i, .rst_ni, .start_i(ar_start), .sqrt_i(ar_sqrt), .num_i(ar_num),
    .den_i(ar_den), .busy_o(ar_busy), .done_o(ar_done), .quo_o(ar_quo),
    .root_o(ar_root));

  assign dx_w = 33'(ex_q) - 33'(tx_q);
  assign dy_w = 33'(ey_q) - 33'(ty_q);
  assign ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
  assign ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
  assign da_w = 21'(ey_aw_q) - 21'(ty_aw_q);
  assign ada_w = da_w[20] ? 21'(-da_w) : 21'(da_w);
  assign am_w = (ada_w >= 21'(pea_pkg::TwoPiQ16)) ? ada_w - 21'(pea_pkg::TwoPiQ16) : ada_w;
  assign lsum_w = {1'b0, lsum_q} + 49'(dist_q);
  assign asum_w = {1'b0, asum_q} + 49'(ang_q);

  assign ar_start = (st_q == StSq || st_q == StDivL || st_q == StDivA) && !ar_busy && !ar_done
                    && !ovf_q;
  assign ar_sqrt = (st_q == StSq);
  assign ar_num = (st_q == StSq) ? sq_q : {17'd0, (st_q == StDivL) ? lsum_q : asum_q};
  assign ar_den = 48'(cnt_q);

  logic [66:0] sqsum_w;
  assign sqsum_w = 67'(ax_w) * 67'(ax_w);
  logic [66:0] sqy_w;
  assign sqy_w = 67'(ay_w) * 67'(ay_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; valid_q <= 1'b0; est_seen_q <= 1'b0; true_seen_q <= 1'b0;
      lsum_q <= '0; asum_q <= '0; cnt_q <= '0; ex_q <= '0; ey_q <= '0; tx_q <= '0;
      ty_q <= '0; ey_aw_q <= '0; ty_aw_q <= '0; cor_go_q <= 1'b0;
      ovf_q <= 1'b0; cmd_q <= '0; px_q <= '0; py_q <= '0;
      qx_q <= '0; qy_q <= '0; qz_q <= '0; qw_q <= '0; sq_q <= '0; dist_q <= '0;
      ang_q <= '0; status_q <= 1'b0; avl_q <= '0; ava_q <= '0; su_q <= '0;
    end else begin
      cor_go_q <= 1'b0;
      if (valid_q && !stall_i) valid_q <= 1'b0;
      unique case (st_q)
        StIdle: if (valid_i && !stall_o) begin
          cmd_q <= cmd_i; px_q <= pos_x_i; py_q <= pos_y_i;
          qx_q <= quat_x_i; qy_q <= quat_y_i; qz_q <= quat_z_i; qw_q <= quat_w_i;
          unique case (cmd_i)
            pea_pkg::CmdEst, pea_pkg::CmdTrue: begin
              st_q <= StYaw; cor_go_q <= 1'b1;
            end
            pea_pkg::CmdTick:
              if (est_seen_q && true_seen_q && cnt_q != CountMax) st_q <= StSqWait;
            default:
              if (cnt_q == '0) begin
                status_q <= 1'b1; avl_q <= '0; ava_q <= '0; su_q <= '0; valid_q <= 1'b1;
              end else begin
                st_q <= StDivL;
              end
          endcase
        end
        StYaw: if (cor_done) begin
          if (cmd_q == pea_pkg::CmdEst) begin
            ex_q <= px_q; ey_q <= py_q; ey_aw_q <= yaw_w; est_seen_q <= 1'b1;
          end else begin
            tx_q <= px_q; ty_q <= py_q; ty_aw_q <= yaw_w; true_seen_q <= 1'b1;
          end
          st_q <= StIdle;
        end
        StSqWait: begin
          sq_q <= 65'(sqsum_w + sqy_w);
          ovf_q <= (sqsum_w + sqy_w) >= 67'h1_0000_0000_0000_0000;
          ang_q <= 18'((am_w > 21'(pea_pkg::PiQ16)) ? 21'(pea_pkg::TwoPiQ16) - am_w : am_w);
          st_q <= StSq;
        end
        StSq: if (ovf_q) begin
          dist_q <= '1; ovf_q <= 1'b0; st_q <= StAcc;
        end else if (ar_done) begin
          dist_q <= ar_root[32] ? 32'hFFFF_FFFF : ar_root[31:0];
          st_q <= StAcc;
        end
        StAcc: begin
          lsum_q <= lsum_w[48] ? pea_pkg::SumMax : lsum_w[47:0];
          asum_q <= asum_w[48] ? pea_pkg::SumMax : asum_w[47:0];
          cnt_q <= cnt_q + COUNT_BITS'(1);
          st_q <= StIdle;
        end
        StDivL: if (ar_done) begin
          avl_q <= ar_quo[31:0]; st_q <= StDivA;
        end
        StDivA: if (ar_done) begin
          ava_q <= ar_quo[17:0]; status_q <= 1'b0; su_q <= 16'(cnt_q);
          valid_q <= 1'b1; lsum_q <= '0; asum_q <= '0; cnt_q <= '0; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign stall_o = (st_q != StIdle) || valid_q;
  assign valid_o = valid_q;
  assign status_o = status_q;
  assign avg_linear_error_o = avl_q;
  assign avg_angular_error_o = ava_q;
  assign samples_used_o = su_q;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> stall_o) else $error("ready while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> lsum_q == '0 && asum_q == '0) else $error("sums without count");
  a_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !status_o |-> su_q != 16'd0) else $error("empty report");
`endif
endmodule
